[hw/rtl/spe_pkg.sv]
`default_nettype none

package spe_pkg;

   // sizes and limits
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_POSITIONS = 4096;
   localparam int CORDIC_STEPS  = 28;
   localparam int EXP_STEPS     = 24;
   localparam int DIV_BITS      = 29;
   localparam int PIPE_STAGES   = CORDIC_STEPS + 8;
   localparam int RSP_LATENCY   = PIPE_STAGES + 1;

   localparam logic [10:0] WIDTH_RESET = 11'd512;

   // 2 * log2(10000) in Q24
   localparam logic [DIV_BITS-1:0] LOG2_1E4_X2 = 29'd445861642;

   // angle constants in Q30
   localparam logic [32:0]        TWO_PI          = 33'd6746518852;
   localparam logic signed [33:0] TWO_PI_S        = 34'sd6746518852;
   localparam logic signed [33:0] THREE_HALF_PI_S = 34'sd5059889139;
   localparam logic signed [33:0] PI_S            = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_S       = 34'sd1686629713;
   localparam logic signed [33:0] QUARTER_PI_S    = 34'sd843314857;
   localparam logic signed [33:0] GAIN_S          = 34'sd652032874;
   localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;

   // floor(2^54 / 2pi_q30): reciprocal used to estimate the turn count
   localparam logic [21:0] TWO_PI_RECIP = 22'((64'd1 << 54) / 64'd6746518852);

   typedef logic [29:0] root_tab_type [EXP_STEPS];

   // sideband that travels with each beat through the datapath
   typedef struct packed {
      logic vld;
      logic err;
      logic cos_ok;
   } tag_type;

   typedef enum logic [3:0] {
      ST_DIV   = 4'b0001,
      ST_EXP   = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_RUN   = 4'b1000
   } fill_state_type;

   // bit by bit integer square root, elaboration only
   function automatic logic [31:0] isqrt64(input logic [63:0] v);
      logic [31:0] res;
      logic [31:0] trial;
      logic [63:0] sq;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = res | (32'd1 << b);
         sq    = 64'(trial) * 64'(trial);
         if (sq <= v) begin
            res = trial;
         end
      end
      return res;
   endfunction

   // successive square roots of one half in Q30: 2^(-1/2^(j+1))
   function automatic root_tab_type exp2_roots();
      root_tab_type tab;
      logic [63:0]  r;
      r = 64'd1 << 29;
      for (int j = 0; j < EXP_STEPS; j++) begin
         r      = 64'(isqrt64(r << 30));
         tab[j] = r[29:0];
      end
      return tab;
   endfunction

   // floor(num / den) by shift and subtract, elaboration only
   function automatic longint unsigned udiv_floor(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rmd;
      quo = 0;
      rmd = 0;
      for (int b = 63; b >= 0; b--) begin
         rmd = {rmd[62:0], num[b]};
         quo = quo << 1;
         if (rmd >= den) begin
            rmd = rmd - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // arctan(2^-i) in Q30 from its power series in Q40, elaboration only
   function automatic logic signed [33:0] cordic_angle(input int unsigned i);
      longint          sum;
      longint          term;
      longint unsigned odd;
      longint unsigned e;
      sum = 0;
      if (i == 0) begin
         return QUARTER_PI_S;
      end
      for (int m = 0; m < 21; m++) begin
         odd = 64'(2 * m + 1);
         if (odd * i <= 40) begin
            e    = 40 - odd * i;
            term = longint'(udiv_floor(64'd1 << e, odd));
            sum  = m[0] ? sum - term : sum + term;
         end
      end
      return 34'((sum + 512) >>> 10);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/sinusoidal_position_encoder.sv]
// Sinusoidal position encoder: sin and cos of position * 10000^(-2k/d), Q1.15.
// Input: a beat is taken at a rising edge with start high and busy low; it
// carries req_position and req_pair_index (pair k covers dimensions 2k, 2k+1).
// Output: rsp_valid strobes for one cycle per beat with sine, cosine, a cosine
// valid flag (2k+1 inside the width) and an index error flag (values zero).
// Config: csr_wr_en writes csr_wr_data into the model width d; the block then
// refills its frequency table and holds busy meanwhile.
// Frequency table: one word per pair in a single-port RAM, filled after reset
// and after every width write by one reused multiplier: a divide, then for
// each pair the exp2 steps and a table write. Nothing is taken while busy.
// Throughput: one beat per cycle once the table is full; the RAM read, turn
// reduction, fold, 28 CORDIC stages and rounding form a fixed pipeline.
// The receiver cannot stall; results leave in order, one per beat.
// Reset clears the pipeline valid tags, sets d to 512 and starts a refill.
`default_nettype none

module sinusoidal_position_encoder #(
   parameter int MAX_WIDTH = spe_pkg::MAX_WIDTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [11:0]        req_position,
   input  wire logic [8:0]         req_pair_index,
   input  wire logic               csr_wr_en,
   input  wire logic [10:0]        csr_wr_data,
   output      logic               rsp_valid,
   output      logic signed [15:0] rsp_sine_value,
   output      logic signed [15:0] rsp_cosine_value,
   output      logic               rsp_cosine_valid,
   output      logic               rsp_index_error
);

   localparam int WIDTH_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
   localparam int PAIRS     = ((WIDTH_CAP + 1) / 2 > 512) ? 512 : (WIDTH_CAP + 1) / 2;
   localparam int AW        = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int KW        = $clog2(PAIRS + 1);
   localparam int STAGES    = spe_pkg::PIPE_STAGES;
   localparam int STEPS     = spe_pkg::CORDIC_STEPS;

   localparam spe_pkg::root_tab_type ROOTS = spe_pkg::exp2_roots();

   // table fill control
   spe_pkg::fill_state_type state_ff, state_in;
   logic [10:0]             width_ff, width_in;
   logic [10:0]             d_eff;
   logic [4:0]              div_cnt_ff, div_cnt_in;
   logic [spe_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [10:0]             rem_ff, rem_in;
   logic [29:0]             t_ff, t_in;
   logic [10:0]             tr_ff, tr_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [4:0]              j_ff, j_in;
   logic [30:0]             acc_ff, acc_in;

   logic [11:0]   div_trial;
   logic          div_ge;
   logic [60:0]   exp_prod;
   logic [60:0]   exp_round;
   logic          frac_bit;
   logic [11:0]   tr_sum;
   logic          tr_wrap;
   logic [KW-1:0] k_inc;
   logic          last_pair;
   logic [30:0]   freq_wr;
   logic          mem_we;

   // frequency table, Q30
   logic [30:0] freq_mem [PAIRS];

   // datapath
   logic                   accept;
   logic                   req_err;
   logic                   req_cos_ok;
   spe_pkg::tag_type       tag_ff [1:STAGES];
   spe_pkg::tag_type       tag_in [1:STAGES];
   logic [11:0]            pos1_ff;
   logic [30:0]            freq1_ff;
   logic [42:0]            prod2_ff;
   logic [42:0]            prod3_ff;
   logic [10:0]            qe3_ff;
   logic [42:0]            recip_prod;
   logic [42:0]            prod4_ff;
   logic [42:0]            qm4_ff;
   logic [43:0]            qm_full;
   logic [33:0]            rem5_ff;
   logic [32:0]            ang6_ff;
   logic signed [33:0]     ang_s;
   logic signed [33:0]     fold_z;
   logic                   fold_neg;
   logic signed [33:0]     cx_ff [STEPS+1];
   logic signed [33:0]     cy_ff [STEPS+1];
   logic signed [33:0]     cz_ff [STEPS+1];
   logic                   neg_ff [STEPS+1];
   logic signed [33:0]     cx_in [1:STEPS];
   logic signed [33:0]     cy_in [1:STEPS];
   logic signed [33:0]     cz_in [1:STEPS];
   logic signed [33:0]     xn_ff;
   logic signed [33:0]     yn_ff;
   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_sine_ff;
   logic signed [15:0]     rsp_cos_ff;
   logic                   rsp_cosv_ff;
   logic                   rsp_err_ff;

   // q30 to q15 with round half up and saturation
   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] s;
      logic signed [19:0] q;
      s = 35'(v) + 35'sd16384;
      q = 20'(s >>> 15);
      if (q > 20'sd32767) begin
         return 16'sh7fff;
      end
      if (q < -20'sd32768) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   assign d_eff = (width_ff > 11'(WIDTH_CAP)) ? 11'(WIDTH_CAP) : width_ff;
   assign busy  = (state_ff != spe_pkg::ST_RUN);

   // fill datapath: divide step, exp2 step, table word
   assign div_trial = {rem_ff, quo_ff[spe_pkg::DIV_BITS-1]};
   assign div_ge    = div_trial >= {1'b0, d_eff};
   assign exp_prod  = 61'(acc_ff) * 61'(ROOTS[j_ff]);
   assign exp_round = exp_prod + (61'd1 << 29);
   assign frac_bit  = t_ff[5'd23 - j_ff];
   assign tr_sum    = {1'b0, tr_ff} + {1'b0, rem_ff};
   assign tr_wrap   = tr_sum >= {1'b0, d_eff};
   assign k_inc     = k_ff + KW'(1);
   assign last_pair = (12'({k_inc, 1'b0}) >= {1'b0, d_eff}) || (k_inc == KW'(PAIRS));
   assign freq_wr   = acc_ff >> t_ff[29:24];
   assign mem_we    = (state_ff == spe_pkg::ST_WRITE);

   // fill sequencer
   always_comb begin
      state_in   = state_ff;
      width_in   = width_ff;
      div_cnt_in = div_cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      t_in       = t_ff;
      tr_in      = tr_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      acc_in     = acc_ff;
      unique case (state_ff)
         spe_pkg::ST_DIV: begin
            rem_in     = div_ge ? 11'(div_trial - {1'b0, d_eff}) : div_trial[10:0];
            quo_in     = {quo_ff[spe_pkg::DIV_BITS-2:0], div_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(spe_pkg::DIV_BITS - 1)) begin
               state_in = (d_eff == 11'd0) ? spe_pkg::ST_RUN : spe_pkg::ST_EXP;
               t_in     = '0;
               tr_in    = '0;
               k_in     = '0;
               j_in     = '0;
               acc_in   = spe_pkg::ONE_Q30;
            end
         end
         spe_pkg::ST_EXP: begin
            if (frac_bit) begin
               acc_in = exp_round[60:30];
            end
            j_in = j_ff + 5'd1;
            if (j_ff == 5'(spe_pkg::EXP_STEPS - 1)) begin
               state_in = spe_pkg::ST_WRITE;
            end
         end
         spe_pkg::ST_WRITE: begin
            k_in     = k_inc;
            t_in     = t_ff + 30'(quo_ff) + 30'(tr_wrap);
            tr_in    = tr_wrap ? 11'(tr_sum - {1'b0, d_eff}) : tr_sum[10:0];
            j_in     = '0;
            acc_in   = spe_pkg::ONE_Q30;
            state_in = last_pair ? spe_pkg::ST_RUN : spe_pkg::ST_EXP;
         end
         spe_pkg::ST_RUN: begin
            state_in = spe_pkg::ST_RUN;
         end
         default: begin
            state_in = spe_pkg::ST_DIV;
         end
      endcase
      // width write restarts the fill
      if (csr_wr_en) begin
         width_in   = csr_wr_data;
         state_in   = spe_pkg::ST_DIV;
         div_cnt_in = '0;
         rem_in     = '0;
         quo_in     = spe_pkg::LOG2_1E4_X2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= spe_pkg::ST_DIV;
         width_ff   <= spe_pkg::WIDTH_RESET;
         div_cnt_ff <= '0;
         rem_ff     <= '0;
         quo_ff     <= spe_pkg::LOG2_1E4_X2;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         div_cnt_ff <= div_cnt_in;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      tr_ff  <= tr_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      acc_ff <= acc_in;
   end

   // table ram: writes only while busy, reads only on accepted beats
   always_ff @(posedge clock) begin
      if (mem_we) begin
         freq_mem[k_ff[AW-1:0]] <= freq_wr;
      end
      if (accept) begin
         freq1_ff <= freq_mem[req_pair_index[AW-1:0]];
      end
   end

   // beat intake and range checks
   assign accept     = start && !busy;
   assign req_err    = ({1'b0, req_pair_index, 1'b0} >= d_eff) ||
                       (17'(req_position) >= 17'(spe_pkg::MAX_POSITIONS));
   assign req_cos_ok = {1'b0, req_pair_index, 1'b1} < d_eff;

   // sideband shift line
   always_comb begin
      tag_in[1] = '{vld: accept, err: req_err, cos_ok: req_cos_ok};
      for (int n = 2; n <= STAGES; n++) begin
         tag_in[n] = tag_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 1; n <= STAGES; n++) begin
            tag_ff[n] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int n = 1; n <= STAGES; n++) begin
            tag_ff[n] <= tag_in[n];
         end
         rsp_valid_ff <= tag_ff[STAGES].vld;
      end
   end

   // angle = position * freq mod 2pi, turn count from a reciprocal estimate
   assign recip_prod = 43'(prod2_ff[42:22]) * 43'(spe_pkg::TWO_PI_RECIP);
   assign qm_full    = 44'(qe3_ff) * 44'(spe_pkg::TWO_PI);

   // fold into [-pi/2, pi/2]
   assign ang_s = signed'({1'b0, ang6_ff});
   always_comb begin
      if (ang_s <= spe_pkg::HALF_PI_S) begin
         fold_z   = ang_s;
         fold_neg = 1'b0;
      end else if (ang_s < spe_pkg::THREE_HALF_PI_S) begin
         fold_z   = ang_s - spe_pkg::PI_S;
         fold_neg = 1'b1;
      end else begin
         fold_z   = ang_s - spe_pkg::TWO_PI_S;
         fold_neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos1_ff  <= req_position;
      prod2_ff <= 43'(pos1_ff) * 43'(freq1_ff);
      prod3_ff <= prod2_ff;
      qe3_ff   <= recip_prod[42:32];
      prod4_ff <= prod3_ff;
      qm4_ff   <= qm_full[42:0];
      rem5_ff  <= 34'(prod4_ff - qm4_ff);
      ang6_ff  <= (rem5_ff >= {1'b0, spe_pkg::TWO_PI}) ?
                  33'(rem5_ff - {1'b0, spe_pkg::TWO_PI}) : rem5_ff[32:0];
      cx_ff[0]  <= spe_pkg::GAIN_S;
      cy_ff[0]  <= '0;
      cz_ff[0]  <= fold_z;
      neg_ff[0] <= fold_neg;
   end

   // rotation-mode cordic, one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      localparam logic signed [33:0] ANGLE = spe_pkg::cordic_angle(i);
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      assign cx_in[i+1] = cz_ff[i][33] ? cx_ff[i] + dx : cx_ff[i] - dx;
      assign cy_in[i+1] = cz_ff[i][33] ? cy_ff[i] - dy : cy_ff[i] + dy;
      assign cz_in[i+1] = cz_ff[i][33] ? cz_ff[i] + ANGLE : cz_ff[i] - ANGLE;
      always_ff @(posedge clock) begin
         cx_ff[i+1]  <= cx_in[i+1];
         cy_ff[i+1]  <= cy_in[i+1];
         cz_ff[i+1]  <= cz_in[i+1];
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   // undo the fold, round to q15, apply the range flags
   always_ff @(posedge clock) begin
      xn_ff <= neg_ff[STEPS] ? -cx_ff[STEPS] : cx_ff[STEPS];
      yn_ff <= neg_ff[STEPS] ? -cy_ff[STEPS] : cy_ff[STEPS];
      rsp_sine_ff <= tag_ff[STAGES].err ? 16'sd0 : to_q15(yn_ff);
      rsp_cos_ff  <= (tag_ff[STAGES].err || !tag_ff[STAGES].cos_ok) ?
                     16'sd0 : to_q15(xn_ff);
      rsp_cosv_ff <= !tag_ff[STAGES].err && tag_ff[STAGES].cos_ok;
      rsp_err_ff  <= tag_ff[STAGES].err;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sine_value   = rsp_sine_ff;
   assign rsp_cosine_value = rsp_cos_ff;
   assign rsp_cosine_valid = rsp_cosv_ff;
   assign rsp_index_error  = rsp_err_ff;

endmodule

`default_nettype wire

[hw/rtl/spe_checker.sv]
`default_nettype none

module spe_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               csr_wr_en,
   input wire logic               rsp_valid,
   input wire logic signed [15:0] rsp_sine_value,
   input wire logic signed [15:0] rsp_cosine_value,
   input wire logic               rsp_cosine_valid,
   input wire logic               rsp_index_error
);

   localparam int LAT = spe_pkg::RSP_LATENCY;

   // reset always starts a table fill
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // a width write always starts a table fill
   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> busy)
      else $error("busy low right after a width write");

   // every taken beat gives a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after an accepted beat");

   // no result without a beat taken the fixed latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without an accepted beat");

   // an index error zeroes the whole result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |->
         (rsp_sine_value == 16'sd0 && rsp_cosine_value == 16'sd0 && !rsp_cosine_valid))
      else $error("index error with nonzero result");

endmodule

bind sinusoidal_position_encoder spe_checker u_spe_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .csr_wr_en        (csr_wr_en),
   .rsp_valid        (rsp_valid),
   .rsp_sine_value   (rsp_sine_value),
   .rsp_cosine_value (rsp_cosine_value),
   .rsp_cosine_valid (rsp_cosine_valid),
   .rsp_index_error  (rsp_index_error)
);

`default_nettype wire
